### rtl/qsort_pkg.sv
// ----------------------------------------------------------------------------
// qsort_pkg
// Shared types for the quicksort sorter: payload structs and width constants.
// ----------------------------------------------------------------------------
package qsort_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CmpW   = 11;
  localparam logic [CmpW-1:0] CmpMax = '1;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] sorted_value;
    logic                     final_res;
    logic [CmpW-1:0]          comparisons;
  } out_item_t;

endpackage

### rtl/qsort_stack.sv
// ----------------------------------------------------------------------------
// qsort_stack
// Range stack: one memory of (lo, hi) pairs, registered read of the top entry.
// ----------------------------------------------------------------------------
module qsort_stack #(
  parameter int unsigned AW = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [2*AW-1:0] wr_data,
  input  logic [AW-1:0]   rd_addr,
  output logic [2*AW-1:0] rd_data
);

  logic [2*AW-1:0] mem [(1<<AW)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/quicksort_sorter_core.sv
// ----------------------------------------------------------------------------
// quicksort_sorter_core
// Collects a set of signed values, sorts them with Lomuto quicksort and streams
// them out in ascending order.
// ----------------------------------------------------------------------------
// Items are loaded one per cycle into the element memory until an item with
// last set arrives (items beyond DEPTH are dropped). The set is then sorted in
// place: ranges are popped from a range stack memory, an optional median-of-
// three step moves the pivot to the end, and a Lomuto partition walks the
// range. Every element access goes through the single-port element memory with
// a registered read: a partition step reads element j, then the slot, then
// compares, and a swap writes the slot and then j. Each item is emitted by a
// read (S_ERD) and a load of the output register (S_EMIT), which waits while a
// held result is not taken. Results carry the partition comparison count of
// their set, final_res marks the largest value. No input is accepted from the
// last item until the final result has been loaded into the output register.
// The pivot bit (cfg_wdata, reset 1) selects median-of-three pivots; write it only while idle.
// ----------------------------------------------------------------------------
module quicksort_sorter_core
  import qsort_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int unsigned AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_POP   = 14'b00000000000010,
    S_RANGE = 14'b00000000000100,
    S_MRD   = 14'b00000000001000, // read a, b of a compare-swap
    S_MRB   = 14'b00000000010000,
    S_MCMP  = 14'b00000000100000,
    S_PIV   = 14'b00000001000000, // read pivot
    S_PRJ   = 14'b00000010000000, // read element j
    S_PRS   = 14'b00000100000000, // read element at slot
    S_PCMP  = 14'b00001000000000,
    S_SWB   = 14'b00010000000000, // write second half of swap
    S_PUSH  = 14'b00100000000000,
    S_ERD   = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // element memory
  logic signed [ValueW-1:0] emem [DEPTH];
  logic [AW-1:0] e_addr;
  logic          e_we;
  logic signed [ValueW-1:0] e_wdata, e_rdata;

  always_ff @(posedge clk) begin
    if (e_we) begin
      emem[e_addr] <= e_wdata;
    end
    e_rdata <= emem[e_addr];
  end

  // range stack
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [2*AW-1:0] s_wdata, s_rdata;

  qsort_stack #(.AW(AW)) u_stack (
    .clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
    .rd_addr(s_raddr), .rd_data(s_rdata)
  );

  logic              pmode_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     sp_r, sp_nxt;
  logic [CmpW-1:0]   cmp_r, cmp_nxt;
  logic [AW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]     j_r, j_nxt, slot_r, slot_nxt;
  logic [AW-1:0]     ma_r, ma_nxt, mb_r, mb_nxt;
  logic [1:0]        mstep_r, mstep_nxt;   // median: 0..2 compare-swaps, 3 = final exchange
  logic [1:0]        pstep_r, pstep_nxt;   // pushes pending: bit1 right, bit0 left
  logic signed [ValueW-1:0] va_r, va_nxt, pv_r, pv_nxt, vj_r, vj_nxt;
  logic [AW-1:0]     swb_addr_r, swb_addr_nxt;
  logic signed [ValueW-1:0] swb_data_r, swb_data_nxt;
  state_t            ret_r, ret_nxt;       // state after a swap completes
  logic              pend_r, pend_nxt;     // partition swap was for j (slot++ after)
  logic              fin_r, fin_nxt;       // final exchange of partition
  logic [CW-1:0]     k_r, k_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         ob_r, ob_nxt;

  logic [AW-1:0] mid;
  logic [AW:0]   lohi_sum;
  assign lohi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = lohi_sum[AW:1];

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = ov_r;
  assign out_item  = ob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmode_r <= 1'b1;
    end else if (cfg_we) begin
      pmode_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; sp_nxt = sp_r; cmp_nxt = cmp_r;
    lo_nxt = lo_r; hi_nxt = hi_r; j_nxt = j_r; slot_nxt = slot_r;
    ma_nxt = ma_r; mb_nxt = mb_r; mstep_nxt = mstep_r; pstep_nxt = pstep_r;
    va_nxt = va_r; pv_nxt = pv_r; vj_nxt = vj_r;
    swb_addr_nxt = swb_addr_r; swb_data_nxt = swb_data_r;
    ret_nxt = ret_r; pend_nxt = pend_r; fin_nxt = fin_r;
    k_nxt = k_r; ov_nxt = ov_r; ob_nxt = ob_r;
    e_addr = cnt_r[AW-1:0]; e_we = 1'b0; e_wdata = in_item.value;
    s_we = 1'b0; s_waddr = sp_r[AW-1:0]; s_wdata = '0;
    s_raddr = AW'(sp_r - CW'(1));
    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < DepthC) begin
            e_we = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_item.last) begin
            cmp_nxt = '0;
            k_nxt = '0;
            if (cnt_nxt >= CW'(2)) begin
              s_we = 1'b1;
              s_waddr = '0;
              s_wdata = {AW'(0), AW'(cnt_nxt - CW'(1))};
              sp_nxt = CW'(1);
              state_nxt = S_POP;
            end else begin
              sp_nxt = '0;
              state_nxt = S_ERD;
            end
          end
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          k_nxt = '0;
          state_nxt = S_ERD;
        end else begin
          sp_nxt = sp_r - CW'(1);
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        lo_nxt = s_rdata[2*AW-1:AW];
        hi_nxt = s_rdata[AW-1:0];
        if (s_rdata[2*AW-1:AW] >= s_rdata[AW-1:0]) begin
          state_nxt = S_POP;
        end else if (pmode_r) begin
          mstep_nxt = 2'd0;
          ma_nxt = s_rdata[2*AW-1:AW];
          mb_nxt = AW'(({1'b0, s_rdata[2*AW-1:AW]} + {1'b0, s_rdata[AW-1:0]}) >> 1);
          state_nxt = S_MRD;
        end else begin
          state_nxt = S_PIV;
        end
      end
      S_MRD: begin
        e_addr = ma_r;
        state_nxt = S_MRB;
      end
      S_MRB: begin
        e_addr = mb_r;
        va_nxt = e_rdata;
        state_nxt = S_MCMP;
      end
      S_MCMP: begin
        // advance the median step, swapping first when needed
        ret_nxt = S_MRD;
        pend_nxt = 1'b0; fin_nxt = 1'b0;
        if (mstep_r == 2'd3 || va_r > e_rdata) begin
          e_addr = ma_r; e_we = 1'b1; e_wdata = e_rdata;
          swb_addr_nxt = mb_r; swb_data_nxt = va_r;
          state_nxt = S_SWB;
        end
        unique case (mstep_r)
          2'd0: begin ma_nxt = lo_r; mb_nxt = hi_r; end
          2'd1: begin ma_nxt = mid;  mb_nxt = hi_r; end
          2'd2: begin ma_nxt = mid;  mb_nxt = hi_r; end
          default: begin ret_nxt = S_PIV; end
        endcase
        mstep_nxt = mstep_r + 2'd1;
        if (!(mstep_r == 2'd3 || va_r > e_rdata)) begin
          state_nxt = S_MRD;
        end
      end
      S_SWB: begin
        e_addr = swb_addr_r; e_we = 1'b1; e_wdata = swb_data_r;
        if (pend_r) slot_nxt = slot_r + AW'(1);
        if (fin_r) begin
          pstep_nxt = 2'b11;
          state_nxt = S_PUSH;
        end else begin
          state_nxt = ret_r;
        end
      end
      S_PIV: begin
        e_addr = hi_r;
        j_nxt = lo_r; slot_nxt = lo_r;
        state_nxt = S_PRJ;
      end
      S_PRJ: begin
        // j only equals lo on the first visit, when the pivot read lands
        if (j_r == lo_r && slot_r == lo_r) begin
          pv_nxt = e_rdata;
        end
        ret_nxt = S_PRJ;
        e_addr = j_r;
        state_nxt = S_PRS;
      end
      S_PRS: begin
        vj_nxt = e_rdata;
        e_addr = slot_r;
        state_nxt = S_PCMP;
      end
      S_PCMP: begin
        pend_nxt = 1'b0; fin_nxt = 1'b0;
        if (j_r == hi_r) begin
          // final exchange slot <-> hi ; vj holds pivot value at hi
          e_addr = slot_r; e_we = 1'b1; e_wdata = vj_r;
          swb_addr_nxt = hi_r; swb_data_nxt = e_rdata;
          fin_nxt = 1'b1;
          state_nxt = S_SWB;
        end else begin
          if (cmp_r != CmpMax) cmp_nxt = cmp_r + CmpW'(1);
          j_nxt = j_r + AW'(1);
          if (vj_r <= pv_r) begin
            e_addr = slot_r; e_we = 1'b1; e_wdata = vj_r;
            swb_addr_nxt = j_r; swb_data_nxt = e_rdata;
            pend_nxt = 1'b1;
            state_nxt = S_SWB;
          end else begin
            state_nxt = S_PRJ;
          end
        end
      end
      S_PUSH: begin
        // slot_r is q
        if (pstep_r[1]) begin
          pstep_nxt[1] = 1'b0;
          if ({1'b0, slot_r} + (AW+1)'(1) < {1'b0, hi_r} && sp_r < DepthC) begin
            s_we = 1'b1;
            s_wdata = {AW'(slot_r + AW'(1)), hi_r};
            sp_nxt = sp_r + CW'(1);
          end
        end else begin
          pstep_nxt = 2'b00;
          if ({1'b0, slot_r} > {1'b0, lo_r} + (AW+1)'(1) && sp_r < DepthC) begin
            s_we = 1'b1;
            s_wdata = {lo_r, AW'(slot_r - AW'(1))};
            sp_nxt = sp_r + CW'(1);
          end
          state_nxt = S_POP;
        end
      end
      S_ERD: begin
        if (k_r == cnt_r) begin
          cnt_nxt = '0; cmp_nxt = '0; sp_nxt = '0;
          state_nxt = S_LOAD;
        end else begin
          e_addr = k_r[AW-1:0];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        e_addr = k_r[AW-1:0];
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ob_nxt.sorted_value = e_rdata;
          ob_nxt.final_res = (k_r + CW'(1) == cnt_r);
          ob_nxt.comparisons = cmp_r;
          k_nxt = k_r + CW'(1);
          state_nxt = S_ERD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0; sp_r <= '0; cmp_r <= '0; ov_r <= 1'b0; k_r <= '0;
      ret_r <= S_MRD; pend_r <= 1'b0; fin_r <= 1'b0;
      mstep_r <= '0; pstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt; sp_r <= sp_nxt; cmp_r <= cmp_nxt; ov_r <= ov_nxt;
      k_r <= k_nxt; ret_r <= ret_nxt; pend_r <= pend_nxt; fin_r <= fin_nxt;
      mstep_r <= mstep_nxt; pstep_r <= pstep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; j_r <= j_nxt; slot_r <= slot_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; va_r <= va_nxt; pv_r <= pv_nxt; vj_r <= vj_nxt;
    swb_addr_r <= swb_addr_nxt; swb_data_r <= swb_data_nxt; ob_r <= ob_nxt;
  end

endmodule
